// ----- design/tlsf_pkg.sv -----
`default_nettype none
package tlsf_pkg;

	localparam int COORD_W = 32;
	localparam int COEF_W  = 64;
	localparam int SCAT_W  = 60;
	localparam int WIDE_W  = 128;
	localparam int STEP_W  = 7;

	// Iteration counts of the shared serial units
	localparam logic [STEP_W-1:0] DIV_STEPS_MEAN = 7'd64;
	localparam logic [STEP_W-1:0] DIV_STEPS_UNIT = 7'd32;
	localparam logic [STEP_W-1:0] SQRT_STEPS     = 7'd64;

	// Scatter sums clamp at this magnitude
	localparam logic [SCAT_W-1:0] SCAT_LIM = SCAT_W'(64'h0400_0000_0000_0000);

	typedef enum logic [1:0] {
		ST_FIT      = 2'd0,
		ST_FALLBACK = 2'd1,
		ST_TOO_FEW  = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_LOAD,
		S_MEAN_X,
		S_MEAN_Y,
		S_WALK,
		S_DRAIN,
		S_SQ_D,
		S_SQ_S,
		S_ROOT1,
		S_NORMAL,
		S_SQ_A,
		S_SQ_B,
		S_ROOT2,
		S_UNIT_A,
		S_UNIT_B,
		S_RD_FIRST,
		S_RD_LAST,
		S_FB_LINE,
		S_PROD_A,
		S_PROD_B,
		S_OFFSET,
		S_OUT
	} fit_state_t;

	// Magnitude of a two's complement word
	function automatic logic [63:0] mag64(input logic [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

endpackage
`default_nettype wire

// ----- design/tlsf_point_mem.sv -----
`default_nettype none
module tlsf_point_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [63:0]   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [63:0]   rd_data
);

	logic [63:0] mem_q [DEPTH];
	logic [63:0] rd_data_q;

	// Write one point per transaction
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// ----- design/tlsf_mul.sv -----
`default_nettype none
module tlsf_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [63:0]                op_a,
	input  logic [63:0]                op_b,
	output logic                       done,
	output logic [tlsf_pkg::WIDE_W-1:0] prod
);
	import tlsf_pkg::*;

	logic [63:0]       a_q, b_q;
	logic [WIDE_W-1:0] acc_q;
	logic [1:0]        phase_q;
	logic              busy_q, done_q;
	logic [31:0]       a_half, b_half;
	logic [63:0]       pp;
	logic [WIDE_W-1:0] pp_wide;
	logic [6:0]        shift_amt;

	// Select one 32x32 partial product per cycle
	always_comb begin
		a_half    = phase_q[1] ? a_q[63:32] : a_q[31:0];
		b_half    = phase_q[0] ? b_q[63:32] : b_q[31:0];
		pp        = 64'(a_half) * 64'(b_half);
		shift_amt = 7'({phase_q[1], 5'd0}) + 7'({phase_q[0], 5'd0});
		pp_wide   = WIDE_W'(pp) << shift_amt;
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= '0;
			end else if (busy_q) begin
				phase_q <= phase_q + 2'd1;
				if (phase_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Accumulate partial products
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= op_a;
			b_q   <= op_b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp_wide;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule
`default_nettype wire

// ----- design/tlsf_div.sv -----
`default_nettype none
module tlsf_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [63:0]                rem_init,
	input  logic [63:0]                num_init,
	input  logic [63:0]                divisor,
	input  logic [tlsf_pkg::STEP_W-1:0] steps,
	output logic                       done,
	output logic [63:0]                quot
);
	import tlsf_pkg::*;

	logic [63:0]       rem_q, num_q, div_q, quot_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q, done_q;
	logic [64:0]       trial;
	logic              ge;
	logic [63:0]       rem_d;

	// Shift in one numerator bit, then compare and subtract
	always_comb begin
		trial = {rem_q, num_q[63]};
		ge    = trial >= {1'b0, div_q};
		rem_d = ge ? 64'(trial - {1'b0, div_q}) : trial[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= steps;
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem_init;
			num_q  <= num_init;
			div_q  <= divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_d;
			num_q  <= {num_q[62:0], 1'b0};
			quot_q <= {quot_q[62:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire

// ----- design/tlsf_sqrt.sv -----
`default_nettype none
module tlsf_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tlsf_pkg::WIDE_W-1:0] radicand,
	output logic                        done,
	output logic [63:0]                 root
);
	import tlsf_pkg::*;

	logic [WIDE_W-1:0] rad_q;
	logic [65:0]       rem_q;
	logic [63:0]       root_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q, done_q;
	logic [67:0]       r2, trial;
	logic              ge;

	// One root bit per cycle, two radicand bits brought down
	always_comb begin
		r2    = {rem_q, rad_q[WIDE_W-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		ge    = r2 >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= SQRT_STEPS;
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[WIDE_W-3:0], 2'b00};
			rem_q  <= ge ? 66'(r2 - trial) : r2[65:0];
			root_q <= {root_q[62:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

// ----- design/tlsf_scatter.sv -----
`default_nettype none
module tlsf_scatter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               clear,
	input  logic                               in_vld,
	input  logic signed [31:0]                 x,
	input  logic signed [31:0]                 y,
	input  logic signed [31:0]                 mean_x,
	input  logic signed [31:0]                 mean_y,
	output logic                               busy,
	output logic [tlsf_pkg::SCAT_W-1:0]        sxx,
	output logic [tlsf_pkg::SCAT_W-1:0]        syy,
	output logic signed [tlsf_pkg::SCAT_W-1:0] sxy
);
	import tlsf_pkg::*;

	logic signed [32:0]       dx, dy;
	logic [31:0]              ux_s2, uy_s2;
	logic                     neg_s2, vld_s2;
	logic [63:0]              pxx_s3, pyy_s3, pxy_s3;
	logic                     neg_s3, vld_s3;
	logic [64:0]              rxx, ryy, rxy;
	logic [SCAT_W-1:0]        sxx_q, syy_q, sxx_sum, syy_sum;
	logic signed [SCAT_W-1:0] sxy_q, sxy_sum, txy;

	// Deviations from the means
	always_comb begin
		dx = {x[31], x} - {mean_x[31], mean_x};
		dy = {y[31], y} - {mean_y[31], mean_y};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= in_vld;
			vld_s3 <= vld_s2;
		end
	end

	// Stage 2: magnitudes; stage 3: products
	always_ff @(posedge clk) begin
		ux_s2  <= dx[32] ? 32'(-dx) : dx[31:0];
		uy_s2  <= dy[32] ? 32'(-dy) : dy[31:0];
		neg_s2 <= dx[32] ^ dy[32];
		pxx_s3 <= 64'(ux_s2) * 64'(ux_s2);
		pyy_s3 <= 64'(uy_s2) * 64'(uy_s2);
		pxy_s3 <= 64'(ux_s2) * 64'(uy_s2);
		neg_s3 <= neg_s2;
	end

	// Round the products to Q.16 and add with saturation
	always_comb begin
		rxx     = 65'(pxx_s3) + 65'd32768;
		ryy     = 65'(pyy_s3) + 65'd32768;
		rxy     = 65'(pxy_s3) + 65'd32768;
		sxx_sum = sxx_q + SCAT_W'(rxx[64:16]);
		syy_sum = syy_q + SCAT_W'(ryy[64:16]);
		txy     = SCAT_W'(rxy[64:16]);
		sxy_sum = neg_s3 ? (sxy_q - txy) : (sxy_q + txy);
	end

	// Stage 4: accumulate
	always_ff @(posedge clk) begin
		if (clear) begin
			sxx_q <= '0;
			syy_q <= '0;
			sxy_q <= '0;
		end else if (vld_s3) begin
			sxx_q <= (sxx_sum > SCAT_LIM) ? SCAT_LIM : sxx_sum;
			syy_q <= (syy_sum > SCAT_LIM) ? SCAT_LIM : syy_sum;
			if (sxy_sum > $signed(SCAT_LIM)) begin
				sxy_q <= $signed(SCAT_LIM);
			end else if (sxy_sum < -$signed(SCAT_LIM)) begin
				sxy_q <= -$signed(SCAT_LIM);
			end else begin
				sxy_q <= sxy_sum;
			end
		end
	end

	assign busy = vld_s2 | vld_s3;
	assign sxx  = sxx_q;
	assign syy  = syy_q;
	assign sxy  = sxy_q;

endmodule
`default_nettype wire

// ----- design/total_least_squares_line_fit.sv -----
// Points load at one transaction per cycle into the point memory while in_stall is low.
// After the transaction marked last, the fit reads each stored point once, with
// serial square roots and divisions and a shared multiplier; a degenerate scatter
// falls back to the first and last points, fewer than two points skip the fit.
// Loading resumes once the result is in the output register.
// Reset clears the count, sums, overflow flag and sequencer; the memory is not cleared.
`default_nettype none
module total_least_squares_line_fit #(
	parameter int MAX_POINTS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic               last_point,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [63:0] coef_a,
	output logic signed [63:0] coef_b,
	output logic signed [63:0] coef_c,
	output logic [1:0]         fit_status
);
	import tlsf_pkg::*;

	localparam int CW    = $clog2(MAX_POINTS + 1);
	localparam int AW    = $clog2(MAX_POINTS);
	localparam int SUM_W = COORD_W + CW;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);

	fit_state_t state_q, state_d;
	logic       entry_q;

	logic                    accept, room, out_free;
	logic [CW-1:0]           cnt_q, walk_q, last_idx;
	logic signed [SUM_W-1:0] sum_x_q, sum_y_q;
	logic                    ovf_q;

	logic signed [31:0] mx_q, my_q, x1_q, y1_q, x2_q, y2_q;
	logic               rd_walk_q, fb_q;
	logic [WIDE_W-1:0]  acc_q;
	logic [63:0]        twor_q, mag_q;
	logic signed [63:0] na_q, nb_q, a_q, b_q, c_q, p_q, r_q;
	status_t            status_q;

	logic               out_valid_q;
	logic signed [63:0] coef_a_q, coef_b_q, coef_c_q;
	logic [1:0]         fit_status_q;

	// memory
	logic          mem_wr_en, mem_rd_en;
	logic [AW-1:0] mem_rd_addr;
	logic [63:0]   mem_rd_data;

	// shared units
	logic              mul_start, mul_done, div_start, div_done, sqrt_start, sqrt_done;
	logic [63:0]       mul_a, mul_b, div_rem, div_num, div_divisor, div_quot, sqrt_root;
	logic [STEP_W-1:0] div_steps;
	logic [WIDE_W-1:0] mul_prod;
	logic              neg_p;

	// scatter sums
	logic                     scat_clear, scat_busy;
	logic [SCAT_W-1:0]        sxx, syy;
	logic signed [SCAT_W-1:0] sxy;

	// derived values
	logic [63:0]        sum_x_mag, sum_y_mag, na_mag, nb_mag, d_mag, sxy2_mag;
	logic [63:0]        a_mag, b_mag, mx_mag, my_mag, x1_mag, y1_mag, x2_mag, y2_mag;
	logic signed [63:0] d_w, na1, nb1, na2, twor_s;
	logic               pick1, degenerate;
	logic [32:0]        unit_rnd;
	logic [31:0]        div_q32;
	logic signed [65:0] diff_n, diff_f;
	logic signed [31:0] rd_x, rd_y;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_LOAD);
	assign room     = cnt_q < MAX_CNT;
	assign out_free = !out_valid_q || !out_stall;
	assign last_idx = cnt_q - CW'(1);
	assign rd_x     = mem_rd_data[63:32];
	assign rd_y     = mem_rd_data[31:0];

	// Magnitudes and normal candidates
	always_comb begin
		sum_x_mag = mag64(64'(sum_x_q));
		sum_y_mag = mag64(64'(sum_y_q));
		na_mag    = mag64(na_q);
		nb_mag    = mag64(nb_q);
		a_mag     = mag64(a_q);
		b_mag     = mag64(b_q);
		mx_mag    = mag64(64'(mx_q));
		my_mag    = mag64(64'(my_q));
		x1_mag    = mag64(64'(x1_q));
		y1_mag    = mag64(64'(y1_q));
		x2_mag    = mag64(64'(x2_q));
		y2_mag    = mag64(64'(y2_q));
		twor_s    = $signed(twor_q);
		d_w       = $signed(64'(sxx)) - $signed(64'(syy));
		d_mag     = mag64(d_w);
		na1       = $signed({{3{sxy[SCAT_W-1]}}, sxy, 1'b0});
		sxy2_mag  = mag64(na1);
		nb1       = -d_w - twor_s;
		na2       = d_w - twor_s;
		pick1     = (na1 != 64'sd0) || (nb1 != 64'sd0);
		degenerate = !pick1 && (na2 == 64'sd0);
		div_q32   = div_quot[31:0];
		unit_rnd  = {1'b0, div_q32} + 33'd1;
		diff_n    = 66'(p_q) - 66'(r_q) + 66'sd536870912;
		diff_f    = 66'(p_q) - 66'(r_q) + 66'sd32768;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_LOAD:     if (accept && last_point) state_d = S_MEAN_X;
			S_MEAN_X: begin
				if (cnt_q < CW'(2)) state_d = S_OUT;
				else if (div_done) state_d = S_MEAN_Y;
			end
			S_MEAN_Y:   if (div_done) state_d = S_WALK;
			S_WALK:     if (walk_q == last_idx) state_d = S_DRAIN;
			S_DRAIN:    if (!rd_walk_q && !scat_busy) state_d = S_SQ_D;
			S_SQ_D:     if (mul_done) state_d = S_SQ_S;
			S_SQ_S:     if (mul_done) state_d = S_ROOT1;
			S_ROOT1:    if (sqrt_done) state_d = S_NORMAL;
			S_NORMAL:   state_d = degenerate ? S_RD_FIRST : S_SQ_A;
			S_SQ_A:     if (mul_done) state_d = S_SQ_B;
			S_SQ_B:     if (mul_done) state_d = S_ROOT2;
			S_ROOT2:    if (sqrt_done) state_d = S_UNIT_A;
			S_UNIT_A:   if (div_done) state_d = S_UNIT_B;
			S_UNIT_B:   if (div_done) state_d = S_PROD_A;
			S_RD_FIRST: state_d = S_RD_LAST;
			S_RD_LAST:  state_d = S_FB_LINE;
			S_FB_LINE:  state_d = S_PROD_A;
			S_PROD_A:   if (mul_done) state_d = S_PROD_B;
			S_PROD_B:   if (mul_done) state_d = S_OFFSET;
			S_OFFSET:   state_d = S_OUT;
			S_OUT:      if (out_free) state_d = S_LOAD;
			default:    state_d = S_LOAD;
		endcase
	end

	// Unit starts, operand selection and memory reads
	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = '0;
		mul_a       = '0;
		mul_b       = '0;
		neg_p       = 1'b0;
		div_rem     = '0;
		div_num     = '0;
		div_divisor = 64'(cnt_q);
		div_steps   = DIV_STEPS_MEAN;
		mul_start   = entry_q && (state_q == S_SQ_D || state_q == S_SQ_S ||
			state_q == S_SQ_A || state_q == S_SQ_B ||
			state_q == S_PROD_A || state_q == S_PROD_B);
		// Start no mean division for a set too small to fit
		div_start   = entry_q && ((state_q == S_MEAN_X && cnt_q >= CW'(2)) ||
			state_q == S_MEAN_Y || state_q == S_UNIT_A || state_q == S_UNIT_B);
		sqrt_start  = entry_q && (state_q == S_ROOT1 || state_q == S_ROOT2);
		scat_clear  = (state_q == S_MEAN_Y) && div_done;
		case (state_q)
			S_MEAN_X: div_num = sum_x_mag + 64'(cnt_q >> 1);
			S_MEAN_Y: div_num = sum_y_mag + 64'(cnt_q >> 1);
			S_WALK: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = walk_q[AW-1:0];
			end
			S_RD_FIRST: mem_rd_en = 1'b1;
			S_RD_LAST: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = last_idx[AW-1:0];
			end
			S_SQ_D: begin
				mul_a = d_mag;
				mul_b = d_mag;
			end
			S_SQ_S: begin
				mul_a = sxy2_mag;
				mul_b = sxy2_mag;
			end
			S_SQ_A: begin
				mul_a = na_mag;
				mul_b = na_mag;
			end
			S_SQ_B: begin
				mul_a = nb_mag;
				mul_b = nb_mag;
			end
			S_UNIT_A: begin
				div_rem     = na_mag >> 1;
				div_num     = {na_mag[0], 63'd0};
				div_divisor = mag_q;
				div_steps   = DIV_STEPS_UNIT;
			end
			S_UNIT_B: begin
				div_rem     = nb_mag >> 1;
				div_num     = {nb_mag[0], 63'd0};
				div_divisor = mag_q;
				div_steps   = DIV_STEPS_UNIT;
			end
			S_PROD_A: begin
				mul_a = fb_q ? x2_mag : a_mag;
				mul_b = fb_q ? y1_mag : mx_mag;
				neg_p = fb_q ? (x2_q[31] ^ y1_q[31]) : ~(a_q[63] ^ mx_q[31]);
			end
			S_PROD_B: begin
				mul_a = fb_q ? x1_mag : b_mag;
				mul_b = fb_q ? y2_mag : my_mag;
				neg_p = fb_q ? (x1_q[31] ^ y2_q[31]) : (b_q[63] ^ my_q[31]);
			end
			default: ;
		endcase
	end

	// Sequencer and load bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			entry_q   <= 1'b0;
			cnt_q     <= '0;
			sum_x_q   <= '0;
			sum_y_q   <= '0;
			ovf_q     <= 1'b0;
			rd_walk_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			entry_q   <= (state_d != state_q);
			rd_walk_q <= (state_q == S_WALK);
			if (accept) begin
				if (room) begin
					cnt_q   <= cnt_q + CW'(1);
					sum_x_q <= sum_x_q + SUM_W'(point_x);
					sum_y_q <= sum_y_q + SUM_W'(point_y);
				end else begin
					ovf_q <= 1'b1;
				end
			end else if (state_q == S_OUT && out_free) begin
				cnt_q   <= '0;
				sum_x_q <= '0;
				sum_y_q <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	// Fit datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_MEAN_X: begin
				if (cnt_q < CW'(2)) begin
					a_q      <= '0;
					b_q      <= '0;
					c_q      <= '0;
					status_q <= ST_TOO_FEW;
				end else if (div_done) begin
					mx_q <= sum_x_q[SUM_W-1] ? -$signed(div_q32) : $signed(div_q32);
				end
			end
			S_MEAN_Y: begin
				if (div_done) begin
					my_q   <= sum_y_q[SUM_W-1] ? -$signed(div_q32) : $signed(div_q32);
					walk_q <= '0;
				end
			end
			S_WALK:  walk_q <= walk_q + CW'(1);
			S_SQ_D:  if (mul_done) acc_q <= mul_prod;
			S_SQ_S:  if (mul_done) acc_q <= acc_q + mul_prod;
			S_ROOT1: if (sqrt_done) twor_q <= sqrt_root;
			S_NORMAL: begin
				na_q <= pick1 ? na1 : na2;
				nb_q <= pick1 ? nb1 : na1;
				fb_q <= degenerate;
			end
			S_SQ_A:  if (mul_done) acc_q <= mul_prod;
			S_SQ_B:  if (mul_done) acc_q <= acc_q + mul_prod;
			S_ROOT2: if (sqrt_done) mag_q <= sqrt_root;
			S_UNIT_A: begin
				if (div_done) begin
					a_q <= na_q[63] ? -$signed(64'(unit_rnd[32:1]))
						: $signed(64'(unit_rnd[32:1]));
				end
			end
			S_UNIT_B: begin
				if (div_done) begin
					b_q <= nb_q[63] ? -$signed(64'(unit_rnd[32:1]))
						: $signed(64'(unit_rnd[32:1]));
				end
			end
			S_RD_LAST: begin
				x1_q <= rd_x;
				y1_q <= rd_y;
			end
			S_FB_LINE: begin
				x2_q <= rd_x;
				y2_q <= rd_y;
				a_q  <= 64'(rd_y) - 64'(y1_q);
				b_q  <= 64'(x1_q) - 64'(rd_x);
			end
			S_PROD_A: begin
				if (mul_done) begin
					p_q <= neg_p ? -$signed(mul_prod[63:0]) : $signed(mul_prod[63:0]);
				end
			end
			S_PROD_B: begin
				if (mul_done) begin
					r_q <= neg_p ? -$signed(mul_prod[63:0]) : $signed(mul_prod[63:0]);
				end
			end
			S_OFFSET: begin
				c_q <= fb_q ? 64'(diff_f >>> 16) : 64'(diff_n >>> 30);
				if (fb_q) begin
					status_q <= ST_FALLBACK;
				end else begin
					status_q <= ovf_q ? ST_OVERFLOW : ST_FIT;
				end
			end
			default: ;
		endcase
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			coef_a_q     <= a_q;
			coef_b_q     <= b_q;
			coef_c_q     <= c_q;
			fit_status_q <= status_q;
		end
	end

	assign mem_wr_en  = accept && room;
	assign out_valid  = out_valid_q;
	assign coef_a     = coef_a_q;
	assign coef_b     = coef_b_q;
	assign coef_c     = coef_c_q;
	assign fit_status = fit_status_q;

	tlsf_point_mem #(
		.DEPTH(MAX_POINTS),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(cnt_q[AW-1:0]),
		.wr_data({point_x, point_y}),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	tlsf_scatter u_scatter (
		.clk   (clk),
		.arst_n(arst_n),
		.clear (scat_clear),
		.in_vld(rd_walk_q),
		.x     (rd_x),
		.y     (rd_y),
		.mean_x(mx_q),
		.mean_y(my_q),
		.busy  (scat_busy),
		.sxx   (sxx),
		.syy   (syy),
		.sxy   (sxy)
	);

	tlsf_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.op_a  (mul_a),
		.op_b  (mul_b),
		.done  (mul_done),
		.prod  (mul_prod)
	);

	tlsf_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.rem_init(div_rem),
		.num_init(div_num),
		.divisor (div_divisor),
		.steps   (div_steps),
		.done    (div_done),
		.quot    (div_quot)
	);

	tlsf_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start),
		.radicand(acc_q),
		.done    (sqrt_done),
		.root    (sqrt_root)
	);

endmodule
`default_nettype wire
